### src/wwkc_pkg.sv
// Shared constants and helpers for the whole-word keyword counter.
package wwkc_pkg;

  localparam int unsigned KW_BYTES   = 8;
  localparam int unsigned KW_W       = 8 * KW_BYTES;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned WORD_IDX_W = 3;
  localparam int unsigned OCC_W      = 24;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_EOF     = 8'hFF;

  typedef logic [KW_W-1:0]  kw_t;
  typedef logic [LEN_W-1:0] len_t;

  function automatic logic is_delim(input logic [7:0] b);
    return (b == CH_COMMA) || (b == CH_SPACE) || (b == CH_PERIOD) ||
           (b == CH_NEWLINE) || (b == CH_NUL) || (b == CH_EOF);
  endfunction

  // Position of the first zero byte, or eight.
  function automatic len_t kw_length(input kw_t kw);
    len_t n;
    logic done;
    n = '0;
    done = 1'b0;
    for (int i = 0; i < KW_BYTES; i++) begin
      if (!done && kw[8*i +: 8] != 8'h00) n = n + len_t'(1);
      else done = 1'b1;
    end
    return n;
  endfunction

  // Keep the low nbytes bytes of a keyword.
  function automatic kw_t kw_trim(input kw_t kw, input len_t nbytes);
    kw_t r;
    r = '0;
    for (int i = 0; i < KW_BYTES; i++) begin
      if (len_t'(i) < nbytes) r[8*i +: 8] = kw[8*i +: 8];
    end
    return r;
  endfunction

endpackage

### src/whole_word_keyword_counter.sv
// Whole-word keyword counter: tokenizer, keyword match, count readout.
//
//  channel   dir  beat contents
//  s_axis    in   tdata[7:0] text_byte; tlast final_byte
//  m_axis    out  tdata[2:0] word_index, [26:3] occurrences; tlast last_count
//  cfg       in   cfg_wr_en, cfg_index (keyword_a..h), cfg_data (64 b)
//
//  One text byte per cycle unless a final byte waits: a byte is held in the
//  input register, and token update, NUM_KEYWORDS keyword compares and counter
//  bumps finish in the cycle that it leaves. A final byte loads a snapshot of
//  the counts which drains at one beat per cycle while m_axis_tready is high
//  (NUM_KEYWORDS beats); a later final byte waits only while that drain runs.
//  rst is synchronous and clears keywords, counts, token and all valid flags.
module whole_word_keyword_counter #(
  parameter int unsigned NUM_KEYWORDS   = 8,
  parameter int unsigned MAX_WORD_BYTES = 8,
  parameter int unsigned COUNT_BITS     = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [wwkc_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [wwkc_pkg::KW_W-1:0]           cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [wwkc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] text_byte
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [wwkc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // word_index, occurrences, pad
  output logic                                m_axis_tlast
);
  import wwkc_pkg::*;

  localparam int unsigned IDX_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam len_t MAX_LEN = len_t'(MAX_WORD_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_KEYWORDS - 1);

  typedef logic [COUNT_BITS-1:0] cnt_t;

  kw_t  keywords [NUM_KEYWORDS];
  cnt_t counts [NUM_KEYWORDS];
  cnt_t counts_next [NUM_KEYWORDS];
  cnt_t snap [NUM_KEYWORDS];

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  kw_t  token_chars, token_chars_next;
  len_t token_length, token_length_next;
  logic token_overflow, token_overflow_next;

  logic             drain_valid;
  logic [IDX_W-1:0] drain_idx;

  logic out_fire, drain_done, drain_free, advance;
  logic delim, eval_en;
  kw_t  app_chars, eval_chars;
  len_t app_length, eval_length;
  logic app_overflow, eval_overflow;
  logic [NUM_KEYWORDS-1:0] hit;
  logic [31:0] occ_wide;

  assign out_fire   = m_axis_tvalid && m_axis_tready;
  assign drain_done = out_fire && (drain_idx == LAST_IDX);
  assign drain_free = !drain_valid || drain_done;
  assign advance    = in_valid && (!in_last || drain_free);
  assign s_axis_tready = !in_valid || advance;

  // Token with the current byte appended.
  always_comb begin
    app_chars    = token_chars;
    app_length   = token_length;
    app_overflow = token_overflow;
    if (token_length < MAX_LEN) begin
      for (int i = 0; i < KW_BYTES; i++) begin
        if (len_t'(i) == token_length) app_chars[8*i +: 8] = in_byte;
      end
      app_length = token_length + len_t'(1);
    end else begin
      app_overflow = 1'b1;
    end
  end

  assign delim         = is_delim(in_byte);
  assign eval_en       = advance && (delim || in_last);
  assign eval_chars    = delim ? token_chars    : app_chars;
  assign eval_length   = delim ? token_length   : app_length;
  assign eval_overflow = delim ? token_overflow : app_overflow;

  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      hit[k] = eval_en && !eval_overflow && (eval_length != '0) &&
               (kw_length(keywords[k]) == eval_length) &&
               (kw_trim(keywords[k], eval_length) == eval_chars);
      counts_next[k] = counts[k];
      if (hit[k] && counts[k] != COUNT_MAX) counts_next[k] = counts[k] + cnt_t'(1);
    end
  end

  always_comb begin
    token_chars_next    = token_chars;
    token_length_next   = token_length;
    token_overflow_next = token_overflow;
    if (advance) begin
      if (delim || in_last) begin
        token_chars_next    = '0;
        token_length_next   = '0;
        token_overflow_next = 1'b0;
      end else begin
        token_chars_next    = app_chars;
        token_length_next   = app_length;
        token_overflow_next = app_overflow;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata[7:0];
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_chars    <= '0;
      token_length   <= '0;
      token_overflow <= 1'b0;
    end else begin
      token_chars    <= token_chars_next;
      token_length   <= token_length_next;
      token_overflow <= token_overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (rst) begin
        keywords[k] <= '0;
        counts[k]   <= '0;
      end else begin
        if (cfg_wr_en && cfg_index == REG_IDX_W'(k)) keywords[k] <= cfg_data;
        if (advance && in_last) counts[k] <= '0;
        else                    counts[k] <= counts_next[k];
      end
      if (advance && in_last) snap[k] <= counts_next[k];
    end
  end

  // Count readout, one keyword per beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      drain_valid <= 1'b0;
      drain_idx   <= '0;
    end else if (advance && in_last) begin
      drain_valid <= 1'b1;
      drain_idx   <= '0;
    end else if (drain_done) begin
      drain_valid <= 1'b0;
      drain_idx   <= '0;
    end else if (out_fire) begin
      drain_idx <= drain_idx + IDX_W'(1);
    end
  end

  assign occ_wide      = 32'(snap[drain_idx]);
  assign m_axis_tvalid = drain_valid;
  assign m_axis_tlast  = (drain_idx == LAST_IDX);
  assign m_axis_tdata  = {{(OUT_TDATA_W - OCC_W - WORD_IDX_W){1'b0}},
                          occ_wide[OCC_W-1:0], WORD_IDX_W'(drain_idx)};

endmodule
